/* rtl/core/assert_macros.svh */
// Assertion macros for the histeq_chk checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define AST_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset masks the check.
`define AST_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/histeq_pkg.sv */
// Package for the histogram equaliser: request/result structs, function codes, sizes.
// No dependencies.
package histeq_pkg;

  localparam int LEVEL_BITS       = 8;
  localparam int LEVELS           = 1 << LEVEL_BITS;
  localparam int DEF_COUNT_WIDTH  = 24;

  // request function codes
  localparam logic FUNC_COUNT = 1'b0;
  localparam logic FUNC_MAP   = 1'b1;

  typedef struct packed {
    logic                  func;
    logic [LEVEL_BITS-1:0] pixel;
    logic                  last;
  } pix_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] value;
    logic                  last_res;
  } res_t;

endpackage

/* rtl/core/histogram_equalizer.sv */
// Histogram equaliser top level: bin memory, map memory, build sequencer, divider.
// Depends on histeq_pkg.
//
// Two-pass 8-bit grey-level equaliser. Count requests (func = count) add their
// pixel to a 256-bin histogram held in a one-port-read, one-port-write synchronous
// RAM; they are taken one per cycle unless a build or a held map request stalls
// them, the read-modify-write of consecutive requests to the same bin being
// covered by a one-deep forwarding register. The count request flagged last starts
// a map build, during which pix_stall is high: one sweep over the bins finds the
// total and the first nonzero CDF value, then each of the 256 map entries takes
// ST_READ, ST_ACC and ST_PREP (entries that map to zero) or adds ST_NUM and an
// 8-step restoring divider, one quotient bit per cycle. The bins are cleared as
// the second sweep reads them. Map requests (func = map) are taken one per cycle
// while no result waits, and present map_mem[pixel] on res via the map read and
// output registers; while a result waits, count requests keep flowing until one
// map request is held behind it. After reset a clearing pass zeroes both memories
// before the first request is taken. Counts saturate at 2**COUNT_WIDTH - 1; a
// single-level image, or a build with no pixels, maps all to 0.
module histogram_equalizer #(
  parameter int COUNT_WIDTH = histeq_pkg::DEF_COUNT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pix_valid,
  output logic             pix_stall,
  input  histeq_pkg::pix_t pix,
  output logic             res_valid,
  input  logic             res_stall,
  output histeq_pkg::res_t res
);
  import histeq_pkg::*;

  localparam int TW = COUNT_WIDTH + LEVEL_BITS;  // sum of all bins
  localparam int DW = TW + 10;                   // 2*num + den
  localparam int SW = TW + 8;                    // 2*den shifted to the top quotient bit
  localparam int QW = LEVEL_BITS;

  localparam logic [2:0] ST_CLEAR = 3'd0;  // post-reset memory clear
  localparam logic [2:0] ST_RUN   = 3'd1;  // taking requests
  localparam logic [2:0] ST_SUM   = 3'd2;  // total / cdfmin sweep
  localparam logic [2:0] ST_READ  = 3'd3;  // read bin, clear it
  localparam logic [2:0] ST_ACC   = 3'd4;  // running cdf
  localparam logic [2:0] ST_PREP  = 3'd5;  // zero test, cdf - cdfmin
  localparam logic [2:0] ST_NUM   = 3'd6;  // load dividend
  localparam logic [2:0] ST_DIV   = 3'd7;  // one quotient bit per cycle

  // memories
  logic [COUNT_WIDTH-1:0] bin_mem [LEVELS];
  logic [QW-1:0]          map_mem [LEVELS];

  logic                   bin_re, bin_we;
  logic [LEVEL_BITS-1:0]  bin_raddr, bin_waddr;
  logic [COUNT_WIDTH-1:0] bin_rdata, bin_wdata;
  logic                   map_re, map_we;
  logic [QW-1:0]          map_rdata, map_wdata;

  // control
  logic [2:0]             state;
  logic [LEVEL_BITS-1:0]  idx;
  logic [LEVEL_BITS:0]    sum_cnt;
  logic                   s1_valid;
  pix_t                   s1;
  logic                   fwd_valid;
  logic [LEVEL_BITS-1:0]  fwd_addr;
  logic [COUNT_WIDTH-1:0] fwd_data;

  // build datapath
  logic [TW-1:0]          total, first, den, run, diff;
  logic [DW-1:0]          div_rem;
  logic [SW-1:0]          div_sh;
  logic [QW-1:0]          div_q;
  logic [2:0]             div_i;

  logic                   accept, s1_count, s1_build, out_free, s1_adv;
  logic [COUNT_WIDTH-1:0] bin_old, bin_inc;
  logic [TW-1:0]          total_next, first_next;
  logic                   zero_map, div_ge;
  logic [QW-1:0]          div_q_next;

  always_ff @(posedge clk) begin
    if (bin_re) begin
      bin_rdata <= bin_mem[bin_raddr];
    end
    if (bin_we) begin
      bin_mem[bin_waddr] <= bin_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (map_re) begin
      map_rdata <= map_mem[pix.pixel];
    end
    if (map_we) begin
      map_mem[idx] <= map_wdata;
    end
  end

  // request path
  assign accept   = pix_valid && !pix_stall;
  assign s1_count = (s1.func == FUNC_COUNT);
  assign s1_build = s1_valid && s1_count && s1.last;
  assign out_free = !res_valid || !res_stall;
  assign s1_adv   = s1_count || out_free;
  // stop at a stalled map request, and behind a last count request (build follows)
  assign pix_stall = (state != ST_RUN) || (s1_valid && !s1_adv) || s1_build;

  // saturating bin increment; forward the previous cycle's write to the same bin
  assign bin_old = (fwd_valid && fwd_addr == s1.pixel) ? fwd_data : bin_rdata;
  assign bin_inc = (&bin_old) ? bin_old : bin_old + 1'b1;

  // sweep accumulators
  assign total_next = total + TW'(bin_rdata);
  assign first_next = (first == '0 && total_next != '0) ? total_next : first;

  assign zero_map   = (den == '0) || (run <= first);
  assign div_ge     = (div_rem >= DW'(div_sh));
  assign div_q_next = {div_q[QW-2:0], div_ge};

  always_comb begin
    bin_re    = 1'b0;
    bin_raddr = pix.pixel;
    bin_we    = 1'b0;
    bin_waddr = idx;
    bin_wdata = '0;
    map_re    = 1'b0;
    map_we    = 1'b0;
    map_wdata = '0;
    case (state)
      ST_CLEAR: begin
        bin_we = 1'b1;
        map_we = 1'b1;
      end
      ST_RUN: begin
        bin_re    = accept && (pix.func == FUNC_COUNT);
        map_re    = accept && (pix.func == FUNC_MAP);
        bin_we    = s1_valid && s1_count;
        bin_waddr = s1.pixel;
        bin_wdata = bin_inc;
      end
      ST_SUM: begin
        bin_re    = !sum_cnt[LEVEL_BITS];
        bin_raddr = sum_cnt[LEVEL_BITS-1:0];
      end
      ST_READ: begin
        bin_re    = 1'b1;
        bin_raddr = idx;
        bin_we    = 1'b1;  // read returns the old count, bin left clear
      end
      ST_PREP: begin
        map_we = zero_map;
      end
      ST_DIV: begin
        map_we    = (div_i == '0);
        map_wdata = div_q_next;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      idx       <= '0;
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          idx <= idx + 1'b1;
          if (&idx) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (accept) begin
            s1_valid <= 1'b1;
          end else if (s1_adv) begin
            s1_valid <= 1'b0;
          end
          if (s1_valid && s1_count) begin
            fwd_valid <= 1'b1;
          end
          if (s1_build) begin
            state   <= ST_SUM;
            sum_cnt <= '0;
            total   <= '0;
            first   <= '0;
            run     <= '0;
            idx     <= '0;
          end
        end
        ST_SUM: begin
          sum_cnt <= sum_cnt + 1'b1;
          if (sum_cnt != '0) begin
            total <= total_next;
            first <= first_next;
          end
          if (sum_cnt[LEVEL_BITS]) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          den   <= total - first;
          state <= ST_ACC;
        end
        ST_ACC: begin
          run   <= run + TW'(bin_rdata);
          state <= ST_PREP;
        end
        ST_PREP: begin
          diff <= run - first;
          if (zero_map) begin
            idx   <= idx + 1'b1;
            state <= (&idx) ? ST_RUN : ST_READ;
          end else begin
            state <= ST_NUM;
          end
        end
        ST_NUM: begin
          // 2*num + den, num = diff * 255
          div_rem <= DW'({diff, 9'b0}) - DW'({diff, 1'b0}) + DW'(den);
          div_sh  <= {den, 8'b0};
          div_i   <= 3'd7;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          if (div_ge) begin
            div_rem <= div_rem - DW'(div_sh);
          end
          div_sh <= div_sh >> 1;
          div_q  <= div_q_next;
          div_i  <= div_i - 1'b1;
          if (div_i == '0) begin
            idx   <= idx + 1'b1;
            state <= (&idx) ? ST_RUN : ST_READ;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // stage-one request and forwarding payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= pix;
    end
    fwd_addr <= s1.pixel;
    fwd_data <= bin_inc;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_valid && !s1_count && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && !s1_count && out_free) begin
      res.value    <= map_rdata;
      res.last_res <= s1.last;
    end
  end

endmodule

/* rtl/core/histeq_chk.sv */
// Port-level checker for the histogram equaliser, bound to the top level.
// Depends on histeq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module histeq_chk (
  input logic             clk,
  input logic             rst,
  input logic             pix_valid,
  input logic             pix_stall,
  input histeq_pkg::pix_t pix,
  input logic             res_valid,
  input logic             res_stall,
  input histeq_pkg::res_t res
);
  import histeq_pkg::*;

  logic take, map_take, build_take;

  assign take       = pix_valid && !pix_stall;
  assign map_take   = take && (pix.func == FUNC_MAP);
  assign build_take = take && (pix.func == FUNC_COUNT) && pix.last;

  `AST_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid, "result dropped while stalled")
  `AST_NEXT(a_res_stable, clk, rst, res_valid && res_stall, $stable(res), "stalled result changed")
  // a new result follows a taken map request, through the map read and result registers
  `AST_IMPL(a_res_cause, clk, rst, $rose(res_valid), $past(map_take, 2), "unrequested result")
  // last count request starts the build
  `AST_NEXT(a_build_stall, clk, rst, build_take, pix_stall, "request taken behind last count")
  // clearing pass follows reset
  `AST_IMPL(a_clear_stall, clk, rst, $fell(rst), pix_stall, "request taken during clear")

endmodule

bind histogram_equalizer histeq_chk u_histeq_chk (.*);

/* tb/sv/tb_histogram_equalizer.sv */
// Self-checking testbench for the histogram equaliser top level.
// Depends on histeq_pkg and histogram_equalizer; directed table, then random image passes.
module tb_histogram_equalizer;
  import histeq_pkg::*;

  // Narrow bins so that saturation is reachable within a short run.
  localparam int CW           = 8;
  localparam int TOP_LEVEL    = LEVELS - 1;
  localparam int RANDOM_ITEMS = 500;
  localparam int SAT_IMAGE    = 3;    // image whose main level overflows its bin
  localparam int SAT_RUN      = 300;
  localparam int DRAIN_IMAGE  = 6;    // sender waits for every result after this one
  localparam int PRESS_IMAGE  = 9;    // receiver holds off once during this map pass
  localparam int PRESS_MAP    = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int END_DRAIN    = 16;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int DIR_ROWS     = 21;

  typedef enum logic {ROW_PRED, ROW_TYPED} row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    pix_t            req;
    logic [7:0]      want_value;
    logic            want_last;
  } dir_row_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic pix_valid = 1'b0;
  logic res_stall = 1'b0;
  pix_t pix       = '0;
  logic pix_stall;
  logic res_valid;
  res_t res;

  // Predictor state: bins, running total and the current map.
  logic [CW-1:0] hist_bins [LEVELS];
  logic [CW-1:0] hist_total;
  logic [7:0]    model_lut [LEVELS];

  res_t equalized_q [$];
  res_t oldest;
  int   miss_count     = 0;
  int   accepted_total = 0;
  int   cycle_count    = 0;
  int   hold_requests  = 0;
  int   hold_served    = 0;
  bit   sender_burst   = 1'b0;

  // Directed requests. Typed rows are the ones whose answer is obvious:
  // map before any build, a single-level image, and a black/white image.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_TYPED, '{FUNC_MAP,   8'd0,   1'b0}, 8'd0,   1'b0},
    '{ROW_TYPED, '{FUNC_MAP,   8'd255, 1'b1}, 8'd0,   1'b1},
    '{ROW_PRED,  '{FUNC_COUNT, 8'd100, 1'b1}, 8'd0,   1'b0},
    '{ROW_TYPED, '{FUNC_MAP,   8'd100, 1'b0}, 8'd0,   1'b0},
    '{ROW_TYPED, '{FUNC_MAP,   8'd255, 1'b1}, 8'd0,   1'b1},
    '{ROW_PRED,  '{FUNC_COUNT, 8'd0,   1'b0}, 8'd0,   1'b0},
    '{ROW_PRED,  '{FUNC_COUNT, 8'd255, 1'b1}, 8'd0,   1'b0},
    '{ROW_TYPED, '{FUNC_MAP,   8'd0,   1'b0}, 8'd0,   1'b0},
    '{ROW_TYPED, '{FUNC_MAP,   8'd128, 1'b0}, 8'd0,   1'b0},
    '{ROW_TYPED, '{FUNC_MAP,   8'd255, 1'b1}, 8'd255, 1'b1},
    '{ROW_PRED,  '{FUNC_COUNT, 8'd10,  1'b0}, 8'd0,   1'b0},
    '{ROW_PRED,  '{FUNC_COUNT, 8'd10,  1'b0}, 8'd0,   1'b0},
    '{ROW_PRED,  '{FUNC_COUNT, 8'd20,  1'b0}, 8'd0,   1'b0},
    '{ROW_PRED,  '{FUNC_MAP,   8'd255, 1'b0}, 8'd0,   1'b0},  // old map mid-count
    '{ROW_PRED,  '{FUNC_COUNT, 8'd30,  1'b1}, 8'd0,   1'b0},
    '{ROW_PRED,  '{FUNC_MAP,   8'd20,  1'b0}, 8'd0,   1'b0},  // exact half, rounds up
    '{ROW_PRED,  '{FUNC_MAP,   8'd25,  1'b0}, 8'd0,   1'b0},  // absent, above first level
    '{ROW_PRED,  '{FUNC_MAP,   8'd15,  1'b0}, 8'd0,   1'b0},  // absent, cdf equals cdfmin
    '{ROW_PRED,  '{FUNC_MAP,   8'd5,   1'b0}, 8'd0,   1'b0},  // below first used level
    '{ROW_PRED,  '{FUNC_MAP,   8'd30,  1'b1}, 8'd0,   1'b0},
    '{ROW_PRED,  '{FUNC_MAP,   8'd10,  1'b0}, 8'd0,   1'b0}
  };

  histogram_equalizer #(
    .COUNT_WIDTH (CW)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_miss(input string msg);
    begin
      $display("[%0t] MISMATCH %s", $time, msg);
      miss_count++;
    end
  endtask

  // Equalisation map from the current bins: round-half-up done in integers.
  task automatic rebuild_lut();
    longint unsigned sum_all, first_cdf, cdf, den, num, q;
    int v;
    begin
      sum_all   = 0;
      first_cdf = 0;
      for (v = 0; v < LEVELS; v++) begin
        sum_all += hist_bins[v];
        if (first_cdf == 0 && sum_all != 0) first_cdf = sum_all;
      end
      den = sum_all - first_cdf;
      cdf = 0;
      for (v = 0; v < LEVELS; v++) begin
        cdf += hist_bins[v];
        if (den == 0 || cdf <= first_cdf) begin
          model_lut[v] = 8'd0;
        end else begin
          num = (cdf - first_cdf) * TOP_LEVEL;
          q   = (2 * num + den) / (2 * den);
          model_lut[v] = (q > TOP_LEVEL) ? 8'(TOP_LEVEL) : q[7:0];
        end
      end
      for (v = 0; v < LEVELS; v++) hist_bins[v] = '0;
      hist_total = '0;
    end
  endtask

  task automatic count_pixel(input logic [7:0] px, input logic fin);
    begin
      if (hist_bins[px] != '1) hist_bins[px] = hist_bins[px] + 1'b1;
      if (hist_total != '1) hist_total = hist_total + 1'b1;
      if (fin) rebuild_lut();
    end
  endtask

  function automatic int pick_gap();
    int r;
    begin
      r = $urandom_range(0, 99);
      if (sender_burst || r < 55) pick_gap = 0;
      else if (r < 90) pick_gap = $urandom_range(1, 3);
      else pick_gap = $urandom_range(5, 40);
    end
  endfunction

  // Offer one request, hold it until taken, then update the predictor.
  task automatic offer_request(input pix_t p, input bit typed, input res_t want);
    int gap;
    begin
      gap = pick_gap();
      if (gap > 0) begin
        pix_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pix_valid <= 1'b1;
      pix       <= p;
      do @(posedge clk); while (pix_stall);
      accepted_total++;
      if (p.func == FUNC_COUNT) begin
        count_pixel(p.pixel, p.last);
      end else begin
        equalized_q.push_back(typed ? want : res_t'{model_lut[p.pixel], p.last});
      end
    end
  endtask

  // One image: a count pass ending in a build, then (usually) a map pass.
  task automatic run_image(input int idx);
    logic [7:0] pool [4];
    int   style, n_count, n_map, k;
    bit   noisy, skip_map;
    pix_t p;
    begin
      sender_burst = ($urandom_range(0, 99) < 25);
      style = $urandom_range(0, 3);
      for (k = 0; k < 4; k++) pool[k] = 8'($urandom_range(0, TOP_LEVEL));
      if (style == 3) begin
        pool[0] = 8'd0;
        pool[1] = 8'(TOP_LEVEL);
      end
      noisy    = ($urandom_range(0, 99) < 12);
      skip_map = noisy && ($urandom_range(0, 1) == 0);
      if (idx == PRESS_IMAGE) skip_map = 1'b0;
      n_count  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
      if (idx == SAT_IMAGE) n_count = SAT_RUN;

      for (k = 0; k < n_count; k++) begin
        p.func = FUNC_COUNT;
        p.last = 1'b0;
        case (style)
          0: begin
            p.pixel = pool[0];
          end
          2: begin
            p.pixel = 8'($urandom_range(0, TOP_LEVEL));
          end
          default: begin
            p.pixel = pool[$urandom_range(0, 3)];
          end
        endcase
        if (idx == SAT_IMAGE) p.pixel = (k % 16 == 0) ? pool[1] : pool[0];
        if (noisy) begin
          // broken pass: stray map requests and early builds
          if ($urandom_range(0, 99) < 20) begin
            p.func = FUNC_MAP;
            p.last = 1'($urandom_range(0, 1));
          end else if ($urandom_range(0, 99) < 10) begin
            p.last = 1'b1;
          end
        end
        if (k == n_count - 1) begin
          p.func = FUNC_COUNT;
          p.last = 1'b1;
        end
        offer_request(p, 1'b0, '0);
      end

      if (!skip_map) begin
        n_map = $urandom_range(1, 16);
        if (idx == PRESS_IMAGE) begin
          // long receiver hold-off while requests keep coming
          n_map        = PRESS_MAP;
          sender_burst = 1'b1;
        end
        for (k = 0; k < n_map; k++) begin
          p.func  = FUNC_MAP;
          p.pixel = $urandom_range(0, 1) ? pool[$urandom_range(0, 3)]
                                         : 8'($urandom_range(0, TOP_LEVEL));
          p.last  = (k == n_map - 1);
          if (noisy) p.last = 1'($urandom_range(0, 1));
          offer_request(p, 1'b0, '0);
          // build is over and maps flow: start the hold-off now
          if (idx == PRESS_IMAGE && k == 0) hold_requests <= hold_requests + 1;
        end
      end

      if (idx == DRAIN_IMAGE) begin
        pix_valid <= 1'b0;
        @(posedge clk);
        while (equalized_q.size() != 0) @(posedge clk);
      end
    end
  endtask

  // Stimulus
  initial begin : stimulus
    int i, idx;
    for (i = 0; i < LEVELS; i++) begin
      hist_bins[i] = '0;
      model_lut[i] = 8'd0;
    end
    hist_total = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_ROWS; i++) begin
      offer_request(dir_tab[i].req, dir_tab[i].kind == ROW_TYPED,
                    res_t'{dir_tab[i].want_value, dir_tab[i].want_last});
    end

    idx = 0;
    while (accepted_total < DIR_ROWS + RANDOM_ITEMS || idx <= PRESS_IMAGE) begin
      run_image(idx);
      idx++;
    end

    pix_valid <= 1'b0;
    @(posedge clk);
    while (equalized_q.size() != 0) @(posedge clk);
    repeat (END_DRAIN) @(posedge clk);
    if (miss_count == 0) begin
      $display("histogram_equalizer: match");
    end else begin
      $display("histogram_equalizer: mismatch");
    end
    $finish;
  end

  // Receiver: random stall runs, plus the requested long hold-off.
  initial begin : receiver
    int run, r;
    @(posedge clk);
    forever begin
      if (hold_requests != hold_served) begin
        hold_served++;
        res_stall <= 1'b1;
        run = HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          res_stall <= 1'b0;
          run = $urandom_range(1, 12);
        end else if (r < 60) begin
          res_stall <= 1'b0;
          run = $urandom_range(40, 120);
        end else if (r < 93) begin
          res_stall <= 1'b1;
          run = $urandom_range(1, 3);
        end else begin
          res_stall <= 1'b1;
          run = $urandom_range(8, 60);
        end
      end
      // a hold-off request cuts the current run short
      repeat (run) begin
        @(posedge clk);
        if (hold_requests != hold_served) break;
      end
    end
  end

  // Result checker: each taken result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (equalized_q.size() == 0) begin
        report_miss($sformatf("unexpected result value %0d last %0d", res.value, res.last_res));
      end else begin
        oldest = equalized_q.pop_front();
        if (res.value != oldest.value)
          report_miss($sformatf("value got %0d want %0d", res.value, oldest.value));
        if (res.last_res != oldest.last_res)
          report_miss($sformatf("last_res got %0d want %0d", res.last_res, oldest.last_res));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("histogram_equalizer: mismatch");
      $finish;
    end
  end

endmodule

/* histogram_equalizer.f */
+incdir+rtl/core
rtl/core/histeq_pkg.sv
rtl/core/histogram_equalizer.sv
rtl/core/histeq_chk.sv
tb/sv/tb_histogram_equalizer.sv
